### design/sorted_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// sorted_priority_queue_macros - assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared types for the sorted priority queue
// Operation codes, entry layout and the structs passed along the cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VERTEX_W = 12;
  localparam int KEY_W    = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [KEY_W-1:0]    key;
  } spq_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t entry;
  } spq_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic       valid;
    logic       stay;
    spq_entry_t entry;
  } spq_link_t;

endpackage

### design/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if - channel interfaces of the sorted priority queue
// Valid/ready channels for queue operations and for their results.
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  spq_op_t             op;
  logic [VERTEX_W-1:0] vertex_id;
  logic [KEY_W-1:0]    distance_key;

  modport source (output valid, op, vertex_id, distance_key, input ready);
  modport sink   (input valid, op, vertex_id, distance_key, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                out_valid;
  logic [VERTEX_W-1:0] out_vertex;
  logic [KEY_W-1:0]    out_distance;
  logic                is_empty;
  logic                dropped;

  modport source (output valid, out_valid, out_vertex, out_distance, is_empty, dropped,
                  input ready);
  modport sink   (input valid, out_valid, out_vertex, out_distance, is_empty, dropped,
                  output ready);
endinterface

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell - one slot of the systolic sorted queue
// Keeps its entry, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  spq_cmd_t  cmd_i,
  input  logic      tie_i,
  input  spq_link_t left_i,
  input  spq_link_t right_i,
  output spq_link_t link_o
);

  logic       valid_r, valid_nxt;
  spq_entry_t entry_r, entry_nxt;
  logic       stay;

  // sorted row: stay bits form a run from the front
  assign stay = (valid_r && (entry_r.key < cmd_i.entry.key)) || tie_i;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (cmd_i.ins && !stay) begin
      if (left_i.stay) begin
        valid_nxt = 1'b1;
        entry_nxt = cmd_i.entry;
      end else begin
        valid_nxt = left_i.valid;
        entry_nxt = left_i.entry;
      end
    end else if (cmd_i.rem) begin
      valid_nxt = right_i.valid;
      entry_nxt = right_i.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign link_o = '{valid: valid_r, stay: stay, entry: entry_r};

endmodule

### design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue - min-priority queue on a row of sorted cells
// Inserts land in key order; removes pop the front slot.
// ----------------------------------------------------------------------------
// channel  dir  fields
// in_if    in   op, vertex_id, distance_key
// out_if   out  out_valid, out_vertex, out_distance, is_empty, dropped
//
// one operation per cycle while in_if is ready: every cell compares its
// key with the new key and shifts in the same cycle, so the row update
// sets the rate; each transfer on in_if yields one result on out_if in the
// next cycle; a registered result stage lets in_if take a transfer
// whenever out_ready is high or the result stage is empty
// reset clears every cell's valid bit; stored keys need no clearing
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  spq_in_if.sink    in_if,
  spq_out_if.source out_if
);

  localparam spq_link_t EDGE_LINK = '{valid: 1'b0, stay: 1'b0, entry: '0};
  localparam spq_link_t FRONT_LINK = '{valid: 1'b0, stay: 1'b1, entry: '0};

  spq_link_t            link [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld_vec;
  spq_cmd_t             cmd;
  logic                 accept, is_ins, full, empty, head_tie;

  logic                 res_valid_r, res_valid_nxt;
  logic                 res_out_valid_r, res_empty_r, res_dropped_r;
  spq_entry_t           res_entry_r;

  assign accept = in_if.valid && in_if.ready;
  assign is_ins = (in_if.op == OP_INSERT);
  assign full   = link[QUEUE_DEPTH-1].valid;
  assign empty  = !link[0].valid;

  assign cmd.ins          = accept && is_ins && !full;
  assign cmd.rem          = accept && !is_ins && !empty;
  assign cmd.entry.vertex = in_if.vertex_id;
  assign cmd.entry.key    = in_if.distance_key;

  // equal key at the head: new entry goes right behind it
  assign head_tie = link[0].valid && (link[0].entry.key == in_if.distance_key);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_link_t left_link, right_link;
    logic      tie;
    if (i == 0) begin : g_front
      assign left_link = FRONT_LINK;
      assign tie       = head_tie;
    end else begin : g_mid
      assign left_link = link[i-1];
      assign tie       = 1'b0;
    end
    if (i == QUEUE_DEPTH-1) begin : g_back
      assign right_link = EDGE_LINK;
    end else begin : g_inner
      assign right_link = link[i+1];
    end
    spq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd_i   (cmd),
      .tie_i   (tie),
      .left_i  (left_link),
      .right_i (right_link),
      .link_o  (link[i])
    );
    assign vld_vec[i] = link[i].valid;
  end

  assign in_if.ready = !res_valid_r || out_if.ready;

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (accept) begin
      res_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_out_valid_r <= cmd.rem;
      res_entry_r     <= cmd.rem ? link[0].entry : '0;
      res_dropped_r   <= is_ins && full;
      if (cmd.ins) begin
        res_empty_r <= 1'b0;
      end else if (cmd.rem) begin
        res_empty_r <= !link[1].valid;
      end else begin
        res_empty_r <= empty;
      end
    end
  end

  assign out_if.valid        = res_valid_r;
  assign out_if.out_valid    = res_out_valid_r;
  assign out_if.out_vertex   = res_entry_r.vertex;
  assign out_if.out_distance = res_entry_r.key;
  assign out_if.is_empty     = res_empty_r;
  assign out_if.dropped      = res_dropped_r;

  // occupied slots always form a run from the front
  `SPQ_ASSERT_NOW(a_packed_front, 1'b1, ((vld_vec >> 1) & ~vld_vec) == '0, "hole in queue")
  `SPQ_ASSERT_NEXT(a_drop_holds, accept && is_ins && full,
                   vld_vec == $past(vld_vec), "dropped insert changed queue")
  `SPQ_ASSERT_NEXT(a_ins_grows, cmd.ins,
                   $countones(vld_vec) == $countones($past(vld_vec)) + 1,
                   "insert did not add one entry")
  `SPQ_ASSERT_NEXT(a_rem_shrinks, cmd.rem,
                   $countones(vld_vec) + 1 == $countones($past(vld_vec)),
                   "remove did not take one entry")

endmodule
